/* src/bpmd_pkg.sv */
`default_nettype none
package bpmd_pkg;

	localparam int MUL_A_W  = 26;
	localparam int MUL_B_W  = 24;
	localparam int PROD_W   = MUL_A_W + MUL_B_W;
	localparam int QUOT_LSB = 32;
	localparam int QUOT_W   = 16;
	localparam int CMP_W    = 9;

	// Reciprocals scaled by 2**32; exact for dividends below 2**24.
	localparam logic [MUL_A_W-1:0] RECIP255 = 26'd16843010;
	localparam logic [MUL_A_W-1:0] RECIP127 = 26'd33818641;
	localparam logic [MUL_A_W-1:0] RECIP128 = 26'd33554432;

	localparam logic [1:0] CFG_MODE    = 2'd0;
	localparam logic [1:0] CFG_REV_CAL = 2'd1;
	localparam logic [1:0] CFG_FWD_CAL = 2'd2;

	localparam logic [1:0] MODE_SPLIT = 2'd0;
	localparam logic [1:0] MODE_REV   = 2'd1;
	localparam logic [1:0] MODE_FWD   = 2'd2;
	localparam logic [1:0] MODE_OFF   = 2'd3;

	localparam logic KIND_COMMAND = 1'b0;
	localparam logic KIND_TICK    = 1'b1;

	typedef enum logic [1:0] {
		STEP_SCALE  = 2'd0,
		STEP_DIV255 = 2'd1,
		STEP_SPAN   = 2'd2,
		STEP_FINAL  = 2'd3
	} step_t;

	typedef struct packed {
		logic  load;
		logic  mul_en;
		step_t step;
		logic  upd;
	} dp_cmd_t;

	typedef struct packed {
		logic need_span;
	} dp_status_t;

endpackage
`default_nettype wire

/* src/bpmd_ctrl.sv */
`default_nettype none
module bpmd_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire                   out_ready,
	input  bpmd_pkg::dp_status_t  status,
	output bpmd_pkg::dp_cmd_t     cmd
);
	import bpmd_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_M1   = 6'b000010,
		S_M2   = 6'b000100,
		S_M3   = 6'b001000,
		S_M4   = 6'b010000,
		S_UPD  = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.mul_en = 1'b0;
		cmd.step   = STEP_SCALE;
		cmd.upd    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_M1;
				end
			end
			S_M1: begin
				cmd.mul_en = 1'b1;
				cmd.step   = STEP_SCALE;
				state_d    = S_M2;
			end
			S_M2: begin
				cmd.mul_en = 1'b1;
				cmd.step   = STEP_DIV255;
				state_d    = status.need_span ? S_M3 : S_UPD;
			end
			S_M3: begin
				cmd.mul_en = 1'b1;
				cmd.step   = STEP_SPAN;
				state_d    = S_M4;
			end
			S_M4: begin
				cmd.mul_en = 1'b1;
				cmd.step   = STEP_FINAL;
				state_d    = S_UPD;
			end
			S_UPD: begin
				if (slot_free) begin
					cmd.upd = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.upd) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

/* src/bpmd_datapath.sv */
`default_nettype none
module bpmd_datapath #(
	parameter int PERIOD = 500
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  bpmd_pkg::dp_cmd_t     cmd,
	output bpmd_pkg::dp_status_t  status,
	input  wire                   kind,
	input  wire signed [7:0]      command,
	input  wire                   cfg_we,
	input  wire [1:0]             cfg_index,
	input  wire [7:0]             cfg_data,
	output logic                  pin_forward,
	output logic                  pin_reverse,
	output logic [8:0]            compare_forward,
	output logic [8:0]            compare_reverse
);
	import bpmd_pkg::*;

	localparam int CW = $clog2(PERIOD + 1);
	localparam logic [CW-1:0] PERIOD_C = CW'(PERIOD);

	logic [1:0]         mode_q;
	logic signed [7:0]  rcal_q, fcal_q, speed_q;
	logic               kind_q;
	logic [CW-1:0]      cnt_q, cnt_d;
	logic               fl_q, rl_q, fl_d, rl_d;
	logic [PROD_W-1:0]  prod_q, prod_d;
	logic [CMP_W-1:0]   cmpf_q, cmpr_q;

	logic signed [9:0]  v_x, m1_x, m2_x;
	logic               neg, nz, is_fwd, is_rev;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [CW-1:0]      mag, fwd, rev;

	assign v_x = 10'(speed_q);
	assign neg = speed_q[7];
	assign nz  = |speed_q;

	always_comb begin
		unique case (mode_q)
			MODE_SPLIT: begin
				priority if (neg) begin
					m1_x = 10'sd127 - 10'(rcal_q);
				end else if (nz) begin
					m1_x = 10'sd128 + 10'(fcal_q);
				end else begin
					m1_x = '0;
				end
			end
			MODE_REV: m1_x = 10'sd127 - v_x;
			MODE_FWD: m1_x = 10'sd128 + v_x;
			MODE_OFF: m1_x = '0;
			default:  m1_x = '0;
		endcase
	end

	assign m2_x = neg ? (10'sd0 - v_x) : v_x;

	always_comb begin
		unique case (cmd.step)
			STEP_SCALE: begin
				mul_a = MUL_A_W'(m1_x[7:0]);
				mul_b = MUL_B_W'(PERIOD_C);
			end
			STEP_DIV255: begin
				mul_a = RECIP255;
				mul_b = prod_q[MUL_B_W-1:0];
			end
			STEP_SPAN: begin
				mul_a = MUL_A_W'(m2_x[7:0]);
				mul_b = MUL_B_W'(prod_q[QUOT_LSB +: QUOT_W]);
			end
			STEP_FINAL: begin
				mul_a = neg ? RECIP128 : RECIP127;
				mul_b = prod_q[MUL_B_W-1:0];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);

	assign mag    = prod_q[QUOT_LSB +: CW];
	assign is_rev = ((mode_q == MODE_SPLIT) && neg) || (mode_q == MODE_REV);
	assign is_fwd = ((mode_q == MODE_SPLIT) && !neg && nz) || (mode_q == MODE_FWD);
	assign fwd    = is_fwd ? mag : '0;
	assign rev    = is_rev ? mag : '0;

	assign status.need_span = (mode_q == MODE_SPLIT);

	always_comb begin
		fl_d  = fl_q;
		rl_d  = rl_q;
		cnt_d = cnt_q;
		if (kind_q == KIND_TICK) begin
			if (cnt_q >= PERIOD_C) begin
				cnt_d = '0;
				fl_d  = (fwd != '0);
				if (rev != '0) begin
					rl_d = 1'b1;
				end
			end else begin
				cnt_d = cnt_q + 1'b1;
			end
			if ((cnt_d == fwd) && (fwd != PERIOD_C)) begin
				fl_d = 1'b0;
			end
			if ((cnt_d == rev) && (rev != PERIOD_C)) begin
				rl_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_SPLIT;
			rcal_q  <= '0;
			fcal_q  <= '0;
			speed_q <= '0;
			cnt_q   <= '0;
			fl_q    <= 1'b0;
			rl_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_MODE:    mode_q <= cfg_data[1:0];
					CFG_REV_CAL: rcal_q <= cfg_data;
					CFG_FWD_CAL: fcal_q <= cfg_data;
					default:     ;
				endcase
			end
			if (cmd.load && (kind == KIND_COMMAND)) begin
				speed_q <= command;
			end
			if (cmd.upd) begin
				cnt_q <= cnt_d;
				fl_q  <= fl_d;
				rl_q  <= rl_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
		end
		if (cmd.mul_en) begin
			prod_q <= prod_d;
		end
		if (cmd.upd) begin
			cmpf_q <= CMP_W'(fwd);
			cmpr_q <= CMP_W'(rev);
		end
	end

	assign pin_forward     = fl_q;
	assign pin_reverse     = rl_q;
	assign compare_forward = cmpf_q;
	assign compare_reverse = cmpr_q;

endmodule
`default_nettype wire

/* src/bidirectional_pwm_motor_drive.sv */
// Channel   Handshake              Payload
// input     in_valid / in_ready    kind, command
// output    out_valid / out_ready  pin_forward, pin_reverse, compare_forward, compare_reverse
// config    cfg_we                 cfg_index, cfg_data
//
// An item is accepted in S_IDLE, takes four steps on the shared multiplier in calibration mode 0
// and two in the other modes (states S_M1 to S_M4), and then updates the outputs in S_UPD.
// Reset clears the configuration registers, the speed, the period counter and both pin levels at once.
// A finished result waits in the output register; the next beat is accepted meanwhile and
// its update waits until that register has been taken.
`default_nettype none
module bidirectional_pwm_motor_drive #(
	parameter int PERIOD = 500
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  wire               kind,
	input  wire signed [7:0]  command,
	output logic              out_valid,
	input  wire               out_ready,
	output logic              pin_forward,
	output logic              pin_reverse,
	output logic [8:0]        compare_forward,
	output logic [8:0]        compare_reverse,
	input  wire               cfg_we,
	input  wire [1:0]         cfg_index,
	input  wire [7:0]         cfg_data
);
	import bpmd_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	bpmd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	bpmd_datapath #(
		.PERIOD (PERIOD)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.kind            (kind),
		.command         (command),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.pin_forward     (pin_forward),
		.pin_reverse     (pin_reverse),
		.compare_forward (compare_forward),
		.compare_reverse (compare_reverse)
	);

endmodule
`default_nettype wire

/* src/bpmd_checker.sv */
`default_nettype none
module bpmd_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_ready,
	input wire        kind,
	input wire [7:0]  command,
	input wire        out_valid,
	input wire        out_ready,
	input wire        pin_forward,
	input wire        pin_reverse,
	input wire [8:0]  compare_forward,
	input wire [8:0]  compare_reverse
);

	// An input beat that is offered stays offered and unchanged until it is taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(kind) && $stable(command))
		else $error("input beat changed before it was accepted");

	// A stalled result holds all of its fields.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pin_forward) &&
			$stable(pin_reverse) && $stable(compare_forward) && $stable(compare_reverse))
		else $error("stalled result changed");

	// At most one channel carries a nonzero compare.
	a_one_channel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (compare_forward == 9'd0) || (compare_reverse == 9'd0))
		else $error("both compares nonzero");

	// The block works on one item at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second beat accepted while an item is in progress");

endmodule

bind bidirectional_pwm_motor_drive bpmd_checker u_bpmd_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_ready        (in_ready),
	.kind            (kind),
	.command         (command),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.pin_forward     (pin_forward),
	.pin_reverse     (pin_reverse),
	.compare_forward (compare_forward),
	.compare_reverse (compare_reverse)
);
`default_nettype wire
